// File: rtl/core/rmr_pkg.sv
package rmr_pkg;

  localparam int DW     = 32;
  localparam int RNG_W  = 31;
  localparam int BEAR_W = 31;
  localparam int PROD_W = 64;
  localparam int ROOT_W = 32;
  localparam int QUO_W  = 41;
  localparam int DVS_W  = ROOT_W + 1;
  localparam int CW     = 35;
  localparam int ZW     = 34;
  localparam int EW     = 37;
  localparam int SAT_W  = 43;

  // stage counts of the range / range-rate path and of the bearing path outside the CORDIC
  localparam int LAT_PROD     = 2;
  localparam int LAT_SQRT     = ROOT_W;
  localparam int LAT_DIV      = QUO_W + 1;
  localparam int LAT_RATE     = LAT_PROD + LAT_SQRT + LAT_DIV;
  localparam int LAT_OUT      = LAT_RATE + 1;
  localparam int LAT_ATAN_FIX = 6;

  localparam logic signed [ZW-1:0]     HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [EW-1:0]     PI_Q30      = 37'sd3373259426;
  localparam logic signed [EW-1:0]     PI_M2_Q30   = 37'sd3373259424;
  localparam logic signed [EW-1:0]     TWO_PI_Q30  = 37'sd6746518852;
  localparam logic signed [EW-1:0]     FOUR_PI_Q30 = 37'sd13493037704;
  localparam logic signed [BEAR_W-1:0] BEAR_LO     = -31'sd843314857;
  localparam logic signed [BEAR_W-1:0] BEAR_HI     = 31'sd843314856;
  localparam logic [QUO_W-1:0]         Q_MAX       = 41'h100_0000_0000;

  typedef logic [29:0]          atan_t;
  typedef logic signed [CW-1:0] cxy_t;
  typedef logic signed [ZW-1:0] cz_t;

  localparam atan_t ATAN_TAB [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

endpackage

// File: rtl/core/rmr_dly.sv
module rmr_dly #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      sr_r[k] <= sr_r[k-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// File: rtl/core/rmr_prod.sv
module rmr_prod import rmr_pkg::*; (
  input  logic                 clk,
  input  logic signed [DW-1:0] pos_x,
  input  logic signed [DW-1:0] pos_y,
  input  logic signed [DW-1:0] vel_x,
  input  logic signed [DW-1:0] vel_y,
  output logic [PROD_W-1:0]    sumsq,
  output logic [PROD_W-1:0]    dot_mag,
  output logic                 dot_neg
);

  logic signed [PROD_W-1:0] sqx_r, sqy_r, dx_r, dy_r;
  logic signed [PROD_W:0]   dot_nxt;
  logic [PROD_W-1:0]        sumsq_r, mag_r;
  logic                     neg_r;

  assign dot_nxt = (PROD_W+1)'(dx_r) + (PROD_W+1)'(dy_r);

  always_ff @(posedge clk) begin
    sqx_r   <= pos_x * pos_x;
    sqy_r   <= pos_y * pos_y;
    dx_r    <= pos_x * vel_x;
    dy_r    <= pos_y * vel_y;
    sumsq_r <= $unsigned(sqx_r) + $unsigned(sqy_r);
    neg_r   <= dot_nxt[PROD_W];
    mag_r   <= dot_nxt[PROD_W] ? PROD_W'(-dot_nxt) : PROD_W'(dot_nxt);
  end

  assign sumsq   = sumsq_r;
  assign dot_mag = mag_r;
  assign dot_neg = neg_r;

endmodule

// File: rtl/core/rmr_sqrt.sv
module rmr_sqrt import rmr_pkg::*; (
  input  logic              clk,
  input  logic [PROD_W-1:0] rad,
  output logic [ROOT_W-1:0] root
);

  localparam int RW = ROOT_W + 2;

  logic [PROD_W-1:0] v_r    [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
    localparam int P = ROOT_W - 1 - k;
    logic [PROD_W-1:0] v_in;
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RW+1:0]     t, trial;

    if (k == 0) begin : g_first
      assign v_in    = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign t     = {rem_in, v_in[2*P+1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      v_r[k] <= v_in;
      if (t >= trial) begin
        rem_r[k]  <= RW'(t - trial);
        root_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= RW'(t);
        root_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// File: rtl/core/rmr_div.sv
module rmr_div import rmr_pkg::*; (
  input  logic              clk,
  input  logic [PROD_W-1:0] dividend,
  input  logic [ROOT_W-1:0] root,
  output logic [QUO_W-1:0]  quo
);

  logic [DVS_W-1:0] rem_r [QUO_W+1];
  logic [DVS_W-1:0] dv_r  [QUO_W+1];
  logic [QUO_W-1:0] lo_r  [QUO_W+1];
  logic [QUO_W-1:0] q_r   [QUO_W+1];
  logic             ovf_r [QUO_W+1];
  logic [DVS_W-1:0] dv_nxt;

  assign dv_nxt = DVS_W'(root) + DVS_W'(1);

  // quotient of 2^41 or more saturates anyway: flag it, divide the rest
  always_ff @(posedge clk) begin
    dv_r[0]  <= dv_nxt;
    rem_r[0] <= DVS_W'(dividend[PROD_W-1:QUO_W]);
    lo_r[0]  <= dividend[QUO_W-1:0];
    q_r[0]   <= '0;
    ovf_r[0] <= DVS_W'(dividend[PROD_W-1:QUO_W]) >= dv_nxt;
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stg
    localparam int B = QUO_W - k;
    logic [DVS_W:0] t;
    logic           ge;

    assign t  = {rem_r[k-1], lo_r[k-1][B]};
    assign ge = t >= {1'b0, dv_r[k-1]};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DVS_W'(t - {1'b0, dv_r[k-1]}) : DVS_W'(t);
      dv_r[k]  <= dv_r[k-1];
      lo_r[k]  <= lo_r[k-1];
      q_r[k]   <= {q_r[k-1][QUO_W-2:0], ge};
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = (ovf_r[QUO_W] || q_r[QUO_W] > Q_MAX) ? Q_MAX : q_r[QUO_W];

endmodule

// File: rtl/core/rmr_atan.sv
module rmr_atan import rmr_pkg::*; #(
  parameter int STAGES = 24
) (
  input  logic                     clk,
  input  logic signed [DW-1:0]     pos_x,
  input  logic signed [DW-1:0]     pos_y,
  input  logic signed [DW-1:0]     bear,
  output logic signed [BEAR_W-1:0] bear_res
);

  // quadrant fold
  cxy_t        px, py, x_nxt, y_nxt, ay;
  cz_t         z_nxt;
  logic [31:0] m_nxt;
  cxy_t        x0_r, y0_r;
  cz_t         z0_r;
  logic [31:0] m0_r;
  logic        zero0_r;

  assign px = CW'(pos_x);
  assign py = CW'(pos_y);

  always_comb begin
    if (px < 0) begin
      if (py >= 0) begin
        x_nxt = py;
        y_nxt = -px;
        z_nxt = HALF_PI_Q30;
      end else begin
        x_nxt = -py;
        y_nxt = px;
        z_nxt = -HALF_PI_Q30;
      end
    end else begin
      x_nxt = px;
      y_nxt = py;
      z_nxt = '0;
    end
    ay    = (y_nxt < 0) ? -y_nxt : y_nxt;
    m_nxt = (x_nxt > ay) ? 32'(x_nxt) : 32'(ay);
  end

  always_ff @(posedge clk) begin
    x0_r    <= x_nxt;
    y0_r    <= y_nxt;
    z0_r    <= z_nxt;
    m0_r    <= m_nxt;
    zero0_r <= (pos_x == '0) && (pos_y == '0);
  end

  // normalize: shift up until the larger magnitude reaches bit 30
  logic [31:0] m_s;
  logic [4:0]  sh;
  cxy_t        x1_r, y1_r;
  cz_t         z1_r;
  logic        zero1_r;

  always_comb begin
    m_s = m0_r;
    sh  = '0;
    if (m_s[31:15] == '0) begin m_s = m_s << 16; sh = sh + 5'd16; end
    if (m_s[31:23] == '0) begin m_s = m_s << 8;  sh = sh + 5'd8;  end
    if (m_s[31:27] == '0) begin m_s = m_s << 4;  sh = sh + 5'd4;  end
    if (m_s[31:29] == '0) begin m_s = m_s << 2;  sh = sh + 5'd2;  end
    if (m_s[31:30] == '0) begin                  sh = sh + 5'd1;  end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x0_r <<< sh;
    y1_r    <= y0_r <<< sh;
    z1_r    <= z0_r;
    zero1_r <= zero0_r;
  end

  // vectoring iterations, one per stage
  cxy_t cx_r [STAGES];
  cxy_t cy_r [STAGES];
  cz_t  cz_r [STAGES];
  logic cn_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_cor
    cxy_t x_in, y_in, xs, ys;
    cz_t  z_in, a;
    logic n_in;

    if (i == 0) begin : g_first
      assign x_in = x1_r;
      assign y_in = y1_r;
      assign z_in = z1_r;
      assign n_in = zero1_r;
    end else begin : g_next
      assign x_in = cx_r[i-1];
      assign y_in = cy_r[i-1];
      assign z_in = cz_r[i-1];
      assign n_in = cn_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign a  = cz_t'({{(ZW-30){1'b0}}, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      cn_r[i] <= n_in;
      if (!y_in[CW-1]) begin
        cx_r[i] <= x_in + ys;
        cy_r[i] <= y_in - xs;
        cz_r[i] <= z_in + a;
      end else begin
        cx_r[i] <= x_in - ys;
        cy_r[i] <= y_in + xs;
        cz_r[i] <= z_in - a;
      end
    end
  end

  // hold the measured bearing alongside
  logic signed [DW-1:0] mb_d;
  cz_t                  zf;

  rmr_dly #(.WIDTH(DW), .DEPTH(STAGES + 2)) u_mb_dly (
    .clk (clk),
    .d   (bear),
    .q   (mb_d)
  );

  assign zf = cn_r[STAGES-1] ? cz_t'(0) : cz_r[STAGES-1];

  // wrap to [-pi, pi) and round to Q2.28
  logic signed [EW-1:0]     e1_r, e2_r, e3_r, t4;
  logic signed [BEAR_W-1:0] b_r;

  assign t4 = (e3_r - PI_M2_Q30) >>> 2;

  always_ff @(posedge clk) begin
    e1_r <= (EW'(mb_d) <<< 2) - EW'(zf) + PI_Q30;
    if (e1_r < 0) begin
      e2_r <= e1_r + FOUR_PI_Q30;
    end else if (e1_r >= FOUR_PI_Q30) begin
      e2_r <= e1_r - FOUR_PI_Q30;
    end else begin
      e2_r <= e1_r;
    end
    e3_r <= (e2_r >= TWO_PI_Q30) ? e2_r - TWO_PI_Q30 : e2_r;
    if (t4 < EW'(BEAR_LO)) begin
      b_r <= BEAR_LO;
    end else if (t4 > EW'(BEAR_HI)) begin
      b_r <= BEAR_HI;
    end else begin
      b_r <= BEAR_W'(t4);
    end
  end

  assign bear_res = b_r;

endmodule

// File: rtl/core/radar_measurement_residual.sv
// Radar measurement residual. Each word on the in_ ports (a predicted state
// and a radar measurement) is taken at any rising edge with start high; busy
// is never raised, so a word may enter in every cycle. The residuals of a
// word appear on the out_ ports for exactly one cycle, marked by out_valid,
// in the order the words came in. The receiver cannot stall the block and
// does not need to: the pipeline has no back-pressure and every word gives
// exactly one result. The latency is set by the range-rate path: two
// multiply stages, a 32-stage square root, one divisor setup stage and a
// 41-stage restoring divider, plus the output register. The bearing path
// (fold, normalize, CORDIC_STAGES vectoring stages, four wrap stages) is
// shorter and is delayed to match.
module radar_measurement_residual import rmr_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DW-1:0]     in_pos_x,
  input  logic signed [DW-1:0]     in_pos_y,
  input  logic signed [DW-1:0]     in_vel_x,
  input  logic signed [DW-1:0]     in_vel_y,
  input  logic [RNG_W-1:0]         in_meas_range,
  input  logic signed [DW-1:0]     in_meas_bearing,
  input  logic signed [DW-1:0]     in_meas_range_rate,
  output logic                     out_valid,
  output logic signed [DW-1:0]     out_range_residual,
  output logic signed [BEAR_W-1:0] out_bearing_residual,
  output logic signed [DW-1:0]     out_range_rate_residual
);

  localparam int BEAR_DLY = LAT_RATE - (CORDIC_STAGES + LAT_ATAN_FIX);

  // clamp to the signed output range
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] lo, hi;
    lo = SAT_W'(-(64'sd1 <<< (DW - 1)));
    hi = SAT_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
    if (v < lo) begin
      sat_dw = DW'(lo);
    end else if (v > hi) begin
      sat_dw = DW'(hi);
    end else begin
      sat_dw = DW'(v);
    end
  endfunction

  assign busy = 1'b0;

  // valid bits travel beside the data; no stall, so they just shift
  logic [LAT_OUT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT_OUT-2:0], start & ~busy};
    end
  end

  // products: sum of squares and the position-velocity dot product
  logic [PROD_W-1:0] sumsq, dot_mag, dot_mag_d;
  logic              dot_neg, dot_neg_d;

  rmr_prod u_prod (
    .clk     (clk),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .vel_x   (in_vel_x),
    .vel_y   (in_vel_y),
    .sumsq   (sumsq),
    .dot_mag (dot_mag),
    .dot_neg (dot_neg)
  );

  // predicted range
  logic [ROOT_W-1:0] root, root_d;

  rmr_sqrt u_sqrt (
    .clk  (clk),
    .rad  (sumsq),
    .root (root)
  );

  // hold the dot product while the root settles
  rmr_dly #(.WIDTH(PROD_W + 1), .DEPTH(LAT_SQRT)) u_dot_dly (
    .clk (clk),
    .d   ({dot_neg, dot_mag}),
    .q   ({dot_neg_d, dot_mag_d})
  );

  // predicted range rate magnitude
  logic [QUO_W-1:0] quo;
  logic             neg_d;

  rmr_div u_div (
    .clk      (clk),
    .dividend (dot_mag_d),
    .root     (root),
    .quo      (quo)
  );

  rmr_dly #(.WIDTH(ROOT_W + 1), .DEPTH(LAT_DIV)) u_root_dly (
    .clk (clk),
    .d   ({dot_neg_d, root}),
    .q   ({neg_d, root_d})
  );

  // measured range and range rate ride along to the output stage
  logic [RNG_W-1:0]     mr_d;
  logic signed [DW-1:0] mrr_d;

  rmr_dly #(.WIDTH(RNG_W + DW), .DEPTH(LAT_RATE)) u_meas_dly (
    .clk (clk),
    .d   ({in_meas_range, in_meas_range_rate}),
    .q   ({mr_d, mrr_d})
  );

  // bearing residual, then align with the rate path
  logic signed [BEAR_W-1:0] bres, bres_d;

  rmr_atan #(.STAGES(CORDIC_STAGES)) u_atan (
    .clk      (clk),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .bear     (in_meas_bearing),
    .bear_res (bres)
  );

  rmr_dly #(.WIDTH(BEAR_W), .DEPTH(BEAR_DLY)) u_bear_dly (
    .clk (clk),
    .d   (bres),
    .q   (bres_d)
  );

  // output stage: residuals and saturation
  logic signed [SAT_W-1:0] rng_diff, rate_s, rate_diff;
  logic signed [DW-1:0]    rng_r, rate_r;
  logic signed [BEAR_W-1:0] bear_r;

  assign rng_diff  = $signed(SAT_W'(mr_d)) - $signed(SAT_W'(root_d));
  assign rate_s    = neg_d ? -$signed(SAT_W'(quo)) : $signed(SAT_W'(quo));
  assign rate_diff = SAT_W'(mrr_d) - rate_s;

  always_ff @(posedge clk) begin
    rng_r  <= sat_dw(rng_diff);
    rate_r <= sat_dw(rate_diff);
    bear_r <= bres_d;
  end

  assign out_valid               = vld_r[LAT_OUT-1];
  assign out_range_residual      = rng_r;
  assign out_bearing_residual    = bear_r;
  assign out_range_rate_residual = rate_r;

endmodule

// File: rtl/core/rmr_chk.sv
module rmr_chk import rmr_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic signed [BEAR_W-1:0] out_bearing_residual
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT_OUT))
    else $error("result without a word taken at the fixed latency");

  a_bear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bearing_residual >= BEAR_LO && out_bearing_residual <= BEAR_HI))
    else $error("bearing residual outside [-pi, pi)");

endmodule

bind radar_measurement_residual rmr_chk u_rmr_chk (.*);

// File: tb/radar_measurement_residual_tb.sv
`timescale 1ns / 100ps

module radar_measurement_residual_tb;
  import rmr_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_CYCLES = LAT_OUT + 20;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  // One measurement word as it goes into the block.
  typedef struct packed {
    logic signed [DW-1:0]  pos_x;
    logic signed [DW-1:0]  pos_y;
    logic signed [DW-1:0]  vel_x;
    logic signed [DW-1:0]  vel_y;
    logic [RNG_W-1:0]      meas_range;
    logic signed [DW-1:0]  meas_bearing;
    logic signed [DW-1:0]  meas_range_rate;
  } meas_word_t;

  // The residual triple that one word produces.
  typedef struct packed {
    logic signed [DW-1:0]     range_res;
    logic signed [BEAR_W-1:0] bearing_res;
    logic signed [DW-1:0]     rate_res;
  } residual_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  meas_word_t word_in;
  logic out_valid;
  logic signed [DW-1:0]     out_range_residual;
  logic signed [BEAR_W-1:0] out_bearing_residual;
  logic signed [DW-1:0]     out_range_rate_residual;

  residual_t pending_residuals[$];
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned cycle_count;

  radar_measurement_residual u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_pos_x                (word_in.pos_x),
    .in_pos_y                (word_in.pos_y),
    .in_vel_x                (word_in.vel_x),
    .in_vel_y                (word_in.vel_y),
    .in_meas_range           (word_in.meas_range),
    .in_meas_bearing         (word_in.meas_bearing),
    .in_meas_range_rate      (word_in.meas_range_rate),
    .out_valid               (out_valid),
    .out_range_residual      (out_range_residual),
    .out_bearing_residual    (out_bearing_residual),
    .out_range_rate_residual (out_range_rate_residual)
  );

  // 20 ns clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor square root of a 64-bit unsigned value, bit by bit.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // Bearing of (px, py) in Q2.30 by a normalized vectoring CORDIC.
  function automatic longint cordic_bearing(input longint px, input longint py);
    longint x, y, z, mag, xs, ys;
    z = 0;
    if (px == 0 && py == 0) return 0;
    // fold the left half plane into the right one by a quarter turn
    if (px < 0) begin
      if (py >= 0) begin
        x = py; y = -px; z = longint'(HALF_PI_Q30);
      end else begin
        x = -py; y = px; z = -longint'(HALF_PI_Q30);
      end
    end else begin
      x = px; y = py;
    end
    mag = (y < 0) ? -y : y;
    if (x > mag) mag = x;
    // normalize so the larger magnitude reaches 2^30
    while (mag < (64'sd1 <<< 30)) begin
      mag = mag * 2; x = x * 2; y = y * 2;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic residual_t predict_residuals(input meas_word_t w);
    residual_t res;
    longint px, py, vx, vy, rate, wrapped, bear;
    longint unsigned ax, ay, rng, t1, t2, mag, quo;
    logic neg1, neg2, neg;
    px = longint'(w.pos_x); py = longint'(w.pos_y);
    vx = longint'(w.vel_x); vy = longint'(w.vel_y);
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    rng = floor_sqrt(ax * ax + ay * ay);
    t1 = ax * longint'((vx < 0) ? -vx : vx);
    t2 = ay * longint'((vy < 0) ? -vy : vy);
    neg1 = (px < 0) != (vx < 0);
    neg2 = (py < 0) != (vy < 0);
    // signed dot product kept as sign and magnitude
    if (neg1 == neg2) begin
      mag = t1 + t2; neg = neg1;
    end else if (t1 >= t2) begin
      mag = t1 - t2; neg = neg1;
    end else begin
      mag = t2 - t1; neg = neg2;
    end
    quo = mag / (rng + 64'd1);
    if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
    rate = neg ? -longint'(quo) : longint'(quo);

    // wrap the Q2.30 difference into [-pi, pi), then round to Q2.28
    wrapped = longint'(w.meas_bearing) * 4 - cordic_bearing(px, py);
    wrapped = (wrapped + longint'(PI_Q30)) % longint'(TWO_PI_Q30);
    if (wrapped < 0) wrapped = wrapped + longint'(TWO_PI_Q30);
    wrapped = wrapped - longint'(PI_Q30);
    bear = clamp((wrapped + 2) >>> 2, longint'(BEAR_LO), longint'(BEAR_HI));

    res.range_res   = DW'(clamp(longint'(w.meas_range) - longint'(rng), SMIN, SMAX));
    res.bearing_res = BEAR_W'(bear);
    res.rate_res    = DW'(clamp(longint'(w.meas_range_rate) - rate, SMIN, SMAX));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Sample on the rising edge; the block drives out_valid for exactly one cycle.
  always @(posedge clk) begin
    residual_t exp_res;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_residuals.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_res = pending_residuals.pop_front();
        if (out_range_residual !== exp_res.range_res)
          report_mismatch($sformatf("range residual got %0d want %0d",
                                    out_range_residual, exp_res.range_res));
        if (out_bearing_residual !== exp_res.bearing_res)
          report_mismatch($sformatf("bearing residual got %0d want %0d",
                                    out_bearing_residual, exp_res.bearing_res));
        if (out_range_rate_residual !== exp_res.rate_res)
          report_mismatch($sformatf("range rate residual got %0d want %0d",
                                    out_range_rate_residual, exp_res.rate_res));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input meas_word_t w);
    @(negedge clk);
    word_in = w;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_residuals.push_back(predict_residuals(w));
    words_sent++;
  endtask

  // Drop start and hold it low for a gap whose length the argument sets.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic meas_word_t make_word(input longint px, input longint py,
                                           input longint vx, input longint vy,
                                           input longint mr, input longint mb,
                                           input longint mrr);
    meas_word_t w;
    w.pos_x = DW'(px); w.pos_y = DW'(py); w.vel_x = DW'(vx); w.vel_y = DW'(vy);
    w.meas_range = RNG_W'(mr); w.meas_bearing = DW'(mb); w.meas_range_rate = DW'(mrr);
    return w;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  // Random word: mostly realistic magnitudes, some full-range noise.
  function automatic meas_word_t random_word();
    meas_word_t w;
    int unsigned shape;
    int unsigned sh;
    shape = $urandom_range(0, 9);
    w.pos_x = rand32(); w.pos_y = rand32();
    w.vel_x = rand32(); w.vel_y = rand32();
    w.meas_range = RNG_W'(rand32()); w.meas_bearing = rand32();
    w.meas_range_rate = rand32();
    if (shape < 6) begin
      // scale down so the range rate lands inside the field
      sh = $urandom_range(4, 24);
      w.pos_x = w.pos_x >>> sh; w.pos_y = w.pos_y >>> sh;
      w.vel_x = w.vel_x >>> $urandom_range(4, 24);
      w.vel_y = w.vel_y >>> $urandom_range(4, 24);
      w.meas_bearing = w.meas_bearing >>> 1;
    end else if (shape == 6) begin
      // on an axis
      if ($urandom_range(0, 1)) w.pos_x = '0; else w.pos_y = '0;
    end else if (shape == 7) begin
      w.pos_x = $signed(rand32()) >>> 30;
      w.pos_y = $signed(rand32()) >>> 30;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Origin, axes, the negative x axis and each quadrant.
  task automatic test_geometry();
    send_word(make_word(0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(0, 0, 32'h7fff_ffff, -32'sh8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, -32'sh8000_0000));
    send_word(make_word(-65536, 0, 65536, 0, 65536, 843314856, 0));
    send_word(make_word(-65536, -1, 0, 0, 65536, -843314857, 0));
    send_word(make_word(65536, 0, 65536, 0, 65536, 0, 65536));
    send_word(make_word(0, 65536, 0, -65536, 65536, 421657428, 0));
    send_word(make_word(0, -65536, 0, 65536, 65536, -421657428, 0));
    send_word(make_word(3 * 65536, 4 * 65536, 65536, 65536, 5 * 65536, 0, 0));
    send_word(make_word(-3 * 65536, 4 * 65536, -65536, 65536, 5 * 65536, 0, 0));
    send_word(make_word(-3 * 65536, -4 * 65536, 65536, -65536, 5 * 65536, 0, 0));
    send_word(make_word(3 * 65536, -4 * 65536, 65536, 65536, 5 * 65536, 0, 0));
    send_word(make_word(1, 1, 1, 1, 1, 1, 1));
    send_word(make_word(-1, -1, -1, -1, 0, -1, -1));
    idle_cycles(3);
  endtask

  // Field extremes and both saturating residuals.
  task automatic test_extremes();
    send_word(make_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        0, 32'h7fff_ffff, -32'sh8000_0000));
    send_word(make_word(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                        -32'sh8000_0000, 0, -32'sh8000_0000, -32'sh8000_0000));
    send_word(make_word(-32'sh8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        -32'sh8000_0000, 31'h7fff_ffff, 0, 32'h7fff_ffff));
    send_word(make_word(1, 0, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff));
    send_word(make_word(1, 0, -32'sh8000_0000, 0, 31'h7fff_ffff, 0, -32'sh8000_0000));
    send_word(make_word(-32'sh8000_0000, 0, 0, 0, 0, 32'h7fff_ffff, 0));
    send_word(make_word(0, -32'sh8000_0000, 0, 32'h7fff_ffff, 0, -32'sh8000_0000, 0));
    send_word(make_word(32'h7fff_ffff, -1, 1, 1, 31'h7fff_ffff, 32'h7fff_ffff, 0));
    idle_cycles(2);
  endtask

  // Random words sent in bursts with random gaps between bursts.
  task automatic test_random_bursts(input int n_words);
    int burst;
    int left;
    left = n_words;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_word(random_word());
      left -= burst;
      // long back-to-back stretches stay possible when the gap is zero
      case ($urandom_range(0, 3))
        0:       ;
        1:       idle_cycles($urandom_range(1, 3));
        default: idle_cycles($urandom_range(1, 90));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    word_in = '0;
    mismatch_count = 0;
    words_sent = 0;
    results_seen = 0;
    cycle_count = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_geometry();
    test_extremes();
    test_random_bursts(850);
    idle_cycles(1);

    // hold until every word has come back, then let the pipe drain
    while (pending_residuals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d measurement words, checked %0d residual words", words_sent,
             results_seen);
    $display("Covered origin, axes, all quadrants, field extremes, saturation, bursts");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
